[src/cop_pkg.sv]
// Shared types and constants for the clock output phase accumulator.
`default_nettype none
package cop_pkg;

	localparam int TIME_W    = 64;
	localparam int CLK_W     = 26;
	localparam int QUO_W     = 25;
	localparam int MUX_W     = 8;
	localparam int CNT_OUT_W = 10;
	localparam int TOTAL_W   = 32;

	localparam logic [MUX_W-1:0] MUX_CLOCK_OUT    = 8'h05;
	localparam logic [QUO_W-1:0] HALF_PERIOD_NUM  = 25'd32000000;
	localparam logic [CLK_W-1:0] DEFAULT_CLOCK_HZ = 26'd24000000;
	localparam int               DEFAULT_MAX_EDGES = 1000;

	localparam logic CMD_POLL       = 1'b0;
	localparam logic CMD_SOFT_RESET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_START_STEP,
		ST_START_ADD,
		ST_CHECK,
		ST_ADVANCE,
		ST_CAP_CHECK,
		ST_CAP_ADD
	} cop_state_t;

endpackage
`default_nettype wire

[src/cop_div.sv]
// Restoring divider: fixed half-period numerator over the clock, one bit per cycle.
`default_nettype none
module cop_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cop_pkg::CLK_W-1:0]   divisor,
	output logic                             done,
	output logic [cop_pkg::QUO_W-1:0]        quotient,
	output logic [cop_pkg::CLK_W-1:0]        remainder
);

	localparam int QW = cop_pkg::QUO_W;
	localparam int CW = cop_pkg::CLK_W;
	localparam int NW = $clog2(QW + 1);

	logic [NW-1:0] cnt_q;
	logic          done_q;
	logic [CW-1:0] div_q;
	logic [CW-1:0] rem_q;
	logic [QW-1:0] quo_q;

	logic [CW:0]   trial;
	logic          fits;
	logic [CW-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[QW-1]};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? CW'(trial - {1'b0, div_q}) : trial[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == NW'(1));
			if (start) begin
				cnt_q <= NW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= cop_pkg::HALF_PERIOD_NUM;
		end else if (cnt_q != '0) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[src/clock_output_phase_accumulator.sv]
// Top level: polled fractional clock divider driving a clock output pin.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, command, now_us,       | into block
//          | pin_mux, sysclk_freq                      |
//  out     | out_valid/out_ready, pin_state, running,  | out of block
//          | toggles_now, total_toggles,               |
//          | next_event_us, half_period_whole_us       |
//  cfg     | cfg_write, cfg_data (default clock in Hz) | into block
//
// A stop or soft reset finishes directly. A poll with the clock output selected
// reruns the bit-serial divider on a clock change, steps and adds when the output
// starts, checks and advances per edge emitted, and adds again at the cap with an
// edge still due. The edge loop shares one step unit and one 64-bit saturating
// adder. in_ready is high only in idle with no result waiting; a result that finds
// the output register full holds in_ready low. Asynchronous reset stops the output.
`default_nettype none
module clock_output_phase_accumulator #(
	parameter int MAX_EDGES_PER_POLL = cop_pkg::DEFAULT_MAX_EDGES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_write,
	input  wire logic [cop_pkg::CLK_W-1:0]         cfg_data,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              command,
	input  wire logic [cop_pkg::TIME_W-1:0]        now_us,
	input  wire logic [cop_pkg::MUX_W-1:0]         pin_mux,
	input  wire logic [cop_pkg::CLK_W-1:0]         sysclk_freq,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   pin_state,
	output logic                                   running,
	output logic [cop_pkg::CNT_OUT_W-1:0]          toggles_now,
	output logic [cop_pkg::TOTAL_W-1:0]            total_toggles,
	output logic [cop_pkg::TIME_W-1:0]             next_event_us,
	output logic [cop_pkg::QUO_W-1:0]              half_period_whole_us
);

	localparam int TW_ = cop_pkg::TIME_W;
	localparam int CW  = cop_pkg::CLK_W;
	localparam int QW  = cop_pkg::QUO_W;
	localparam int SW  = QW + 1;
	localparam int NCW = $clog2(MAX_EDGES_PER_POLL + 1);
	localparam int KW  = (NCW > cop_pkg::CNT_OUT_W) ? NCW : cop_pkg::CNT_OUT_W;
	localparam logic [TW_-1:0] NEVER = '1;

	cop_pkg::cop_state_t state_q, state_d;
	logic finish_q, finish_d;

	// block state
	logic [CW-1:0]               default_clock_q;
	logic                        active_q;
	logic                        level_q;
	logic [QW-1:0]               whole_step_q;
	logic [CW-1:0]               frac_step_q;
	logic [CW-1:0]               rem_sum_q;
	logic [CW-1:0]               last_clock_q;
	logic [TW_-1:0]              next_edge_q;
	logic [cop_pkg::TOTAL_W-1:0] edge_count_q;

	// per-item working registers
	logic [TW_-1:0] now_q;
	logic [KW-1:0]  toggles_q;
	logic [SW-1:0]  step_q;

	// output register
	logic                          out_valid_q;
	logic                          pin_state_q;
	logic                          running_q;
	logic [cop_pkg::CNT_OUT_W-1:0] toggles_now_q;
	logic [cop_pkg::TOTAL_W-1:0]   total_q;
	logic [TW_-1:0]                next_event_q;
	logic [QW-1:0]                 half_whole_q;

	logic          accept;
	logic [CW-1:0] eff_clock;
	logic          clock_change;
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] div_quo;
	logic [CW-1:0] div_rem;

	logic [CW:0]    rsum_add;
	logic           rsum_carry;
	logic [CW-1:0]  rsum_new;
	logic [SW-1:0]  step_raw;
	logic [SW-1:0]  step_val;

	logic [TW_-1:0] add_base;
	logic [TW_:0]   add_sum;
	logic [TW_-1:0] sat_sum;

	logic          due;
	logic [KW-1:0] toggles_inc;
	logic          cap_hit;
	logic          out_free;

	// Bresenham step: whole part plus one when the remainder wraps, never 0
	always_comb begin
		rsum_add   = {1'b0, rem_sum_q} + {1'b0, frac_step_q};
		rsum_carry = rsum_add >= {1'b0, last_clock_q};
		rsum_new   = rsum_carry ? CW'(rsum_add - {1'b0, last_clock_q}) : rsum_add[CW-1:0];
		step_raw   = {1'b0, whole_step_q} + SW'(rsum_carry);
		step_val   = (step_raw == '0) ? SW'(1) : step_raw;
	end

	// shared saturating schedule adder
	always_comb begin
		add_base = (state_q == cop_pkg::ST_ADVANCE) ? next_edge_q : now_q;
		add_sum  = {1'b0, add_base} + (TW_ + 1)'(step_q);
		sat_sum  = add_sum[TW_] ? NEVER : add_sum[TW_-1:0];
	end

	always_comb begin
		accept    = in_valid && in_ready;
		if (sysclk_freq != '0) begin
			eff_clock = sysclk_freq;
		end else if (default_clock_q != '0) begin
			eff_clock = default_clock_q;
		end else begin
			eff_clock = CW'(1);
		end
		clock_change = eff_clock != last_clock_q;
		due          = active_q && (next_edge_q != NEVER) && (now_q >= next_edge_q);
		toggles_inc  = toggles_q + KW'(1);
		cap_hit      = toggles_inc >= KW'(MAX_EDGES_PER_POLL);
		out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cop_pkg::ST_IDLE;
			finish_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			finish_q <= finish_d;
		end
	end

	// next state; finish_q marks an item whose result waits for the output register
	always_comb begin
		state_d   = state_q;
		finish_d  = finish_q;
		div_start = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			cop_pkg::ST_IDLE: begin
				if (finish_q) begin
					if (out_free) begin
						finish_d = 1'b0;
					end
				end else begin
					in_ready = 1'b1;
					if (in_valid) begin
						if (command == cop_pkg::CMD_SOFT_RESET) begin
							finish_d = 1'b1;
						end else if (pin_mux == cop_pkg::MUX_CLOCK_OUT) begin
							if (clock_change) begin
								div_start = 1'b1;
								state_d   = cop_pkg::ST_DIV;
							end else if (!active_q) begin
								state_d = cop_pkg::ST_START_STEP;
							end else begin
								state_d = cop_pkg::ST_CHECK;
							end
						end else begin
							finish_d = 1'b1;
						end
					end
				end
			end
			cop_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = active_q ? cop_pkg::ST_CHECK : cop_pkg::ST_START_STEP;
				end
			end
			cop_pkg::ST_START_STEP: state_d = cop_pkg::ST_START_ADD;
			cop_pkg::ST_START_ADD:  state_d = cop_pkg::ST_CHECK;
			cop_pkg::ST_CHECK: begin
				if (due) begin
					state_d = cop_pkg::ST_ADVANCE;
				end else begin
					state_d  = cop_pkg::ST_IDLE;
					finish_d = 1'b1;
				end
			end
			cop_pkg::ST_ADVANCE: begin
				state_d = cap_hit ? cop_pkg::ST_CAP_CHECK : cop_pkg::ST_CHECK;
			end
			cop_pkg::ST_CAP_CHECK: begin
				if (due) begin
					state_d = cop_pkg::ST_CAP_ADD;
				end else begin
					state_d  = cop_pkg::ST_IDLE;
					finish_d = 1'b1;
				end
			end
			cop_pkg::ST_CAP_ADD: begin
				state_d  = cop_pkg::ST_IDLE;
				finish_d = 1'b1;
			end
			default: state_d = cop_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_clock_q <= cop_pkg::DEFAULT_CLOCK_HZ;
			active_q        <= 1'b0;
			level_q         <= 1'b0;
			whole_step_q    <= '0;
			frac_step_q     <= '0;
			rem_sum_q       <= '0;
			last_clock_q    <= '0;
			next_edge_q     <= NEVER;
			edge_count_q    <= '0;
		end else begin
			if (cfg_write) begin
				default_clock_q <= cfg_data;
			end
			case (state_q)
				cop_pkg::ST_IDLE: begin
					if (accept) begin
						if (command == cop_pkg::CMD_SOFT_RESET) begin
							active_q     <= 1'b0;
							level_q      <= 1'b0;
							whole_step_q <= '0;
							frac_step_q  <= '0;
							rem_sum_q    <= '0;
							last_clock_q <= '0;
							next_edge_q  <= NEVER;
							edge_count_q <= '0;
						end else if (pin_mux == cop_pkg::MUX_CLOCK_OUT) begin
							if (clock_change) begin
								last_clock_q <= eff_clock;
								rem_sum_q    <= '0;
							end
						end else if (active_q) begin
							active_q    <= 1'b0;
							level_q     <= 1'b0;
							next_edge_q <= NEVER;
						end
					end
				end
				cop_pkg::ST_DIV: begin
					if (div_done) begin
						whole_step_q <= (div_quo == '0 && div_rem == '0) ? QW'(1) : div_quo;
						frac_step_q  <= div_rem;
					end
				end
				cop_pkg::ST_START_STEP: begin
					rem_sum_q <= rsum_new;
					active_q  <= 1'b1;
					level_q   <= 1'b1;
				end
				cop_pkg::ST_START_ADD: next_edge_q <= sat_sum;
				cop_pkg::ST_CHECK: begin
					if (due) begin
						rem_sum_q    <= rsum_new;
						level_q      <= ~level_q;
						edge_count_q <= edge_count_q + cop_pkg::TOTAL_W'(1);
					end
				end
				cop_pkg::ST_ADVANCE: next_edge_q <= sat_sum;
				cop_pkg::ST_CAP_CHECK: begin
					if (due) begin
						rem_sum_q <= rsum_new;
					end
				end
				cop_pkg::ST_CAP_ADD: next_edge_q <= sat_sum;
				default: ;
			endcase
		end
	end

	// per-item registers; accept also clears the count, so a soft reset reports none
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q     <= now_us;
			toggles_q <= '0;
		end
		if (state_q == cop_pkg::ST_ADVANCE) begin
			toggles_q <= toggles_inc;
		end
		if (state_q == cop_pkg::ST_START_STEP || state_q == cop_pkg::ST_CHECK ||
				state_q == cop_pkg::ST_CAP_CHECK) begin
			step_q <= step_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cop_pkg::ST_IDLE && finish_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cop_pkg::ST_IDLE && finish_q && out_free) begin
			pin_state_q   <= level_q;
			running_q     <= active_q;
			toggles_now_q <= toggles_q[cop_pkg::CNT_OUT_W-1:0];
			total_q       <= edge_count_q;
			next_event_q  <= active_q ? next_edge_q : NEVER;
			half_whole_q  <= whole_step_q;
		end
	end

	cop_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.divisor   (eff_clock),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign out_valid            = out_valid_q;
	assign pin_state            = pin_state_q;
	assign running              = running_q;
	assign toggles_now          = toggles_now_q;
	assign total_toggles        = total_q;
	assign next_event_us        = next_event_q;
	assign half_period_whole_us = half_whole_q;

endmodule
`default_nettype wire

[tb/clkout_checker.sv]
// Checker for the clock output divider: predicts every result and compares it.
module clkout_checker #(
	parameter int EDGE_CAP = cop_pkg::DEFAULT_MAX_EDGES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [cop_pkg::CLK_W-1:0]       cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            command,
	input  logic [cop_pkg::TIME_W-1:0]      now_us,
	input  logic [cop_pkg::MUX_W-1:0]       pin_mux,
	input  logic [cop_pkg::CLK_W-1:0]       sysclk_freq,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            pin_state,
	input  logic                            running,
	input  logic [cop_pkg::CNT_OUT_W-1:0]   toggles_now,
	input  logic [cop_pkg::TOTAL_W-1:0]     total_toggles,
	input  logic [cop_pkg::TIME_W-1:0]      next_event_us,
	input  logic [cop_pkg::QUO_W-1:0]       half_period_whole_us,
	output int                              fail_count,
	output int                              open_items
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                          pin;
		logic                          run;
		logic [cop_pkg::CNT_OUT_W-1:0] toggles;
		logic [cop_pkg::TOTAL_W-1:0]   total;
		logic [cop_pkg::TIME_W-1:0]    next_at;
		logic [cop_pkg::QUO_W-1:0]     whole;
	} pin_result_t;

	localparam logic [cop_pkg::TIME_W-1:0] NEVER = '1;
	localparam int unsigned HALF_NUM = 32000000;

	logic [cop_pkg::CLK_W-1:0]   dflt_hz;
	logic                        on;
	logic                        lvl;
	int unsigned                 whole_us;
	int unsigned                 frac_step;
	int unsigned                 rem_acc;
	int unsigned                 cur_hz;
	logic [cop_pkg::TIME_W-1:0]  next_edge;
	logic [cop_pkg::TOTAL_W-1:0] edges;
	int                          fails = 0;
	pin_result_t                 expected_q[$];

	function automatic void clear_divider();
		on = 1'b0;
		lvl = 1'b0;
		whole_us = 0;
		frac_step = 0;
		rem_acc = 0;
		cur_hz = 0;
		next_edge = NEVER;
		edges = '0;
	endfunction

	function automatic logic [cop_pkg::TIME_W-1:0] sat_sum(logic [cop_pkg::TIME_W-1:0] a,
			int unsigned b);
		logic [cop_pkg::TIME_W:0] s;
		s = {1'b0, a} + (cop_pkg::TIME_W + 1)'(b);
		return s[cop_pkg::TIME_W] ? NEVER : s[cop_pkg::TIME_W-1:0];
	endfunction

	// whole part plus one when the remainder accumulator wraps, never below 1 us
	function automatic int unsigned bres_step();
		int unsigned d;
		d = whole_us;
		rem_acc += frac_step;
		if (rem_acc >= cur_hz) begin
			rem_acc -= cur_hz;
			d++;
		end
		return (d == 0) ? 1 : d;
	endfunction

	function automatic pin_result_t predict_poll(logic cmd, logic [cop_pkg::TIME_W-1:0] t,
			logic [cop_pkg::MUX_W-1:0] mux, logic [cop_pkg::CLK_W-1:0] hz);
		int unsigned eff;
		int unsigned tog;
		pin_result_t r;
		tog = 0;
		if (cmd == cop_pkg::CMD_SOFT_RESET) begin
			clear_divider();
		end else begin
			if (mux == cop_pkg::MUX_CLOCK_OUT) begin
				eff = 32'(hz);
				if (eff == 0)
					eff = 32'(dflt_hz);
				if (eff == 0)
					eff = 1;
				if (eff != cur_hz) begin
					cur_hz = eff;
					whole_us = HALF_NUM / eff;
					frac_step = HALF_NUM % eff;
					rem_acc = 0;
					if (whole_us == 0 && frac_step == 0)
						whole_us = 1;
				end
				if (!on) begin
					on = 1'b1;
					lvl = 1'b1;
					next_edge = sat_sum(t, bres_step());
				end
			end else if (on) begin
				on = 1'b0;
				next_edge = NEVER;
				lvl = 1'b0;
			end
			while (on && next_edge != NEVER && t >= next_edge) begin
				lvl = ~lvl;
				edges++;
				next_edge = sat_sum(next_edge, bres_step());
				tog++;
				if (tog >= EDGE_CAP) begin
					// cap reached with edges still due: pull the schedule up to now
					if (next_edge != NEVER && t >= next_edge)
						next_edge = sat_sum(t, bres_step());
					break;
				end
			end
		end
		r.pin = lvl;
		r.run = on;
		r.toggles = tog[cop_pkg::CNT_OUT_W-1:0];
		r.total = edges;
		r.next_at = on ? next_edge : NEVER;
		r.whole = whole_us[cop_pkg::QUO_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [cop_pkg::TIME_W-1:0] want,
			logic [cop_pkg::TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_result_t exp_r;
		if (!arst_n) begin
			clear_divider();
			dflt_hz = cop_pkg::DEFAULT_CLOCK_HZ;
			expected_q.delete();
			open_items <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result item arrived with none expected");
					fails++;
				end else begin
					exp_r = expected_q.pop_front();
					check_field("pin_state", cop_pkg::TIME_W'(exp_r.pin),
						cop_pkg::TIME_W'(pin_state));
					check_field("running", cop_pkg::TIME_W'(exp_r.run),
						cop_pkg::TIME_W'(running));
					check_field("toggles_now", cop_pkg::TIME_W'(exp_r.toggles),
						cop_pkg::TIME_W'(toggles_now));
					check_field("total_toggles", cop_pkg::TIME_W'(exp_r.total),
						cop_pkg::TIME_W'(total_toggles));
					check_field("next_event_us", exp_r.next_at, next_event_us);
					check_field("half_period_whole_us", cop_pkg::TIME_W'(exp_r.whole),
						cop_pkg::TIME_W'(half_period_whole_us));
				end
			end
			if (cfg_write)
				dflt_hz = cfg_data;
			if (in_valid && in_ready)
				expected_q.push_back(predict_poll(command, now_us, pin_mux, sysclk_freq));
			open_items <= expected_q.size();
		end
		fail_count <= fails;
	end

endmodule

[tb/tb_clock_output_phase_accumulator.sv]
// Testbench top: drives polls and default clock writes into the divider, gives the verdict.
module tb_clock_output_phase_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cop_pkg::TIME_W-1:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFE;
	localparam int SETTLE_CYCLES = 2 * cop_pkg::DEFAULT_MAX_EDGES + 100;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [cop_pkg::CLK_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          command = cop_pkg::CMD_POLL;
	logic [cop_pkg::TIME_W-1:0]    now_us = '0;
	logic [cop_pkg::MUX_W-1:0]     pin_mux = '0;
	logic [cop_pkg::CLK_W-1:0]     sysclk_freq = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          pin_state;
	logic                          running;
	logic [cop_pkg::CNT_OUT_W-1:0] toggles_now;
	logic [cop_pkg::TOTAL_W-1:0]   total_toggles;
	logic [cop_pkg::TIME_W-1:0]    next_event_us;
	logic [cop_pkg::QUO_W-1:0]     half_period_whole_us;

	int                            send_idle_pct = 29;
	int                            recv_idle_pct = 55;
	int                            fail_count;
	int                            open_items;
	logic [cop_pkg::CLK_W-1:0]     dflt_shadow = cop_pkg::DEFAULT_CLOCK_HZ;

	always #5ns clk = ~clk;

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	clock_output_phase_accumulator dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_write            (cfg_write),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.command              (command),
		.now_us               (now_us),
		.pin_mux              (pin_mux),
		.sysclk_freq          (sysclk_freq),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.pin_state            (pin_state),
		.running              (running),
		.toggles_now          (toggles_now),
		.total_toggles        (total_toggles),
		.next_event_us        (next_event_us),
		.half_period_whole_us (half_period_whole_us)
	);

	clkout_checker chk (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_write            (cfg_write),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.command              (command),
		.now_us               (now_us),
		.pin_mux              (pin_mux),
		.sysclk_freq          (sysclk_freq),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.pin_state            (pin_state),
		.running              (running),
		.toggles_now          (toggles_now),
		.total_toggles        (total_toggles),
		.next_event_us        (next_event_us),
		.half_period_whole_us (half_period_whole_us),
		.fail_count           (fail_count),
		.open_items           (open_items)
	);

	task automatic send_item(logic cmd, logic [cop_pkg::TIME_W-1:0] t,
			logic [cop_pkg::MUX_W-1:0] mux, logic [cop_pkg::CLK_W-1:0] hz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		now_us <= t;
		pin_mux <= mux;
		sysclk_freq <= hz;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold the sender off until every outstanding item has its result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_items != 0)
			@(posedge clk);
	endtask

	task automatic write_default_clock(logic [cop_pkg::CLK_W-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		dflt_shadow = v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_soft_reset();
		send_item(cop_pkg::CMD_SOFT_RESET, {$urandom, $urandom},
			cop_pkg::MUX_W'($urandom_range(255)),
			cop_pkg::CLK_W'($urandom_range(0, 50000000)));
	endtask

	// mostly a running output with time creeping forward; jumps, stops and resets mixed in
	task automatic random_items(int count);
		logic [cop_pkg::TIME_W-1:0] t;
		logic [cop_pkg::CLK_W-1:0]  hz;
		logic [cop_pkg::MUX_W-1:0]  mux;
		int unsigned                pick;
		int unsigned                eff;
		int unsigned                span;
		t = cop_pkg::TIME_W'($urandom_range(0, 100000));
		hz = '0;
		repeat (count) begin
			if ($urandom_range(99) < 8) begin
				pick = $urandom_range(9);
				if (pick < 3)
					hz = '0;
				else if (pick < 6)
					hz = cop_pkg::CLK_W'($urandom_range(1000000, 50000000));
				else if (pick < 7)
					hz = cop_pkg::CLK_W'($urandom_range(1, 2000));
				else if (pick < 9)
					hz = cop_pkg::CLK_W'($urandom_range(0, 50000000));
				else
					hz = cop_pkg::CLK_W'($urandom_range(32000000, 50000000));
			end
			eff = (hz != 0) ? 32'(hz) : ((dflt_shadow != 0) ? 32'(dflt_shadow) : 1);
			span = 3 * (32000000 / eff) + 3;
			pick = $urandom_range(99);
			if (pick < 80)
				t += cop_pkg::TIME_W'($urandom_range(0, span));
			else if (pick < 88)
				t -= cop_pkg::TIME_W'($urandom_range(0, 50));
			else if (pick < 92)
				t += cop_pkg::TIME_W'($urandom_range(1000, 30000));
			else if (pick < 97)
				t = {$urandom, $urandom};
			else
				t = TIME_MAX - cop_pkg::TIME_W'($urandom_range(0, 300));
			if (t == '1)
				t = TIME_MAX;
			mux = ($urandom_range(99) < 88) ? cop_pkg::MUX_CLOCK_OUT
				: cop_pkg::MUX_W'($urandom_range(255));
			if ($urandom_range(99) < 3)
				send_soft_reset();
			else
				send_item(cop_pkg::CMD_POLL, t, mux, hz);
			if ($urandom_range(199) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(cop_pkg::CMD_POLL, 64'd0, 8'd0, 26'd0);
		send_item(cop_pkg::CMD_POLL, 64'd0, cop_pkg::MUX_CLOCK_OUT, 26'd0);
		send_item(cop_pkg::CMD_POLL, 64'd12, cop_pkg::MUX_CLOCK_OUT, 26'd0);
		send_item(cop_pkg::CMD_POLL, 64'd7, cop_pkg::MUX_CLOCK_OUT, 26'd0);
		send_item(cop_pkg::CMD_POLL, 64'd20, cop_pkg::MUX_CLOCK_OUT, 26'd32000000);
		send_item(cop_pkg::CMD_POLL, 64'd30, cop_pkg::MUX_CLOCK_OUT, 26'd50000000);
		send_item(cop_pkg::CMD_POLL, 64'd31, cop_pkg::MUX_CLOCK_OUT, 26'd33554431);
		send_item(cop_pkg::CMD_POLL, 64'd40, cop_pkg::MUX_CLOCK_OUT, 26'd1);
		send_item(cop_pkg::CMD_POLL, 64'd32000100, cop_pkg::MUX_CLOCK_OUT, 26'd1);
		send_item(cop_pkg::CMD_POLL, 64'd32000200, cop_pkg::MUX_CLOCK_OUT, 26'd3);
		send_item(cop_pkg::CMD_POLL, 64'd96000300, cop_pkg::MUX_CLOCK_OUT, 26'd3);
		send_item(cop_pkg::CMD_POLL, 64'd96000400, cop_pkg::MUX_CLOCK_OUT, 26'd50000000);
		// far enough ahead to hit the per-poll edge cap
		send_item(cop_pkg::CMD_POLL, 64'd96010000, cop_pkg::MUX_CLOCK_OUT, 26'd50000000);
		send_item(cop_pkg::CMD_POLL, 64'd96010001, 8'd4, 26'd50000000);
		send_item(cop_pkg::CMD_POLL, 64'd96010002, 8'hFF, 26'd50000000);
		// start at the end of time: the schedule saturates to never
		send_item(cop_pkg::CMD_POLL, TIME_MAX, cop_pkg::MUX_CLOCK_OUT, 26'd24000000);
		send_item(cop_pkg::CMD_POLL, TIME_MAX, cop_pkg::MUX_CLOCK_OUT, 26'd24000000);
		send_soft_reset();
		send_item(cop_pkg::CMD_POLL, TIME_MAX - 1, cop_pkg::MUX_CLOCK_OUT, 26'd24000000);
		send_item(cop_pkg::CMD_POLL, TIME_MAX, cop_pkg::MUX_CLOCK_OUT, 26'd24000000);
		send_soft_reset();
		// zero default clock falls back to 1 Hz
		write_default_clock(26'd0);
		send_item(cop_pkg::CMD_POLL, 64'd100, cop_pkg::MUX_CLOCK_OUT, 26'd0);
		send_item(cop_pkg::CMD_POLL, 64'd32000200, cop_pkg::MUX_CLOCK_OUT, 26'd0);
		write_default_clock(26'd1);
		send_item(cop_pkg::CMD_POLL, 64'd64000300, cop_pkg::MUX_CLOCK_OUT, 26'd0);

		write_default_clock(26'd50000000);
		random_items(375);

		drain();
		send_idle_pct = 55;
		recv_idle_pct = 29;
		write_default_clock(cop_pkg::CLK_W'($urandom_range(1, 50000000)));
		random_items(375);

		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_default_clock(cop_pkg::DEFAULT_CLOCK_HZ);
		random_items(375);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_clock_output_phase_accumulator: done, clean");
		else
			$display("tb_clock_output_phase_accumulator: done, errors");
		$finish;
	end

	initial begin
		#100ms;
		$display("tb_clock_output_phase_accumulator: done, errors");
		$finish;
	end

endmodule

[clock_output_phase_accumulator.f]
src/cop_pkg.sv
src/cop_div.sv
src/clock_output_phase_accumulator.sv
tb/clkout_checker.sv
tb/tb_clock_output_phase_accumulator.sv
